>>> rtl/cab_pkg.sv
// Shared types and constants for the closest-approach box collision block.
package cab_pkg;

    localparam int COORD_W = 16;
    localparam int SIZE_W = 12;
    localparam int TIME_W = 16;
    localparam int TIME_FRAC_BITS_DEF = 8;

    localparam logic signed [TIME_W-1:0] K_MAX = 16'sh7FFF;
    localparam logic signed [TIME_W-1:0] K_MIN = 16'sh8000;

    typedef struct packed {
        logic signed [COORD_W-1:0] self_x;
        logic signed [COORD_W-1:0] self_y;
        logic signed [COORD_W-1:0] vel_x;
        logic signed [COORD_W-1:0] vel_y;
        logic        [SIZE_W-1:0]  self_width;
        logic        [SIZE_W-1:0]  self_height;
        logic signed [COORD_W-1:0] other_x;
        logic signed [COORD_W-1:0] other_y;
        logic        [SIZE_W-1:0]  other_width;
        logic        [SIZE_W-1:0]  other_height;
    } cab_req_t;

    typedef struct packed {
        logic                     hit;
        logic signed [TIME_W-1:0] approach_time;
    } cab_rsp_t;

endpackage

>>> rtl/cab_stream_if.sv
// Valid/ready stream interface used for the request and response channels.
interface cab_stream_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> rtl/closest_approach_box_collision_top.sv
// Closest-approach box collision test, fully pipelined with a restoring divider.
//
//  channel  dir  type       content
//  req      in   cab_req_t  moving box, velocity, still box
//  rsp      out  cab_rsp_t  hit, approach_time (Q.TIME_FRAC_BITS frames)
//
// One request per cycle while rsp is not stalled; 17 of the pipeline stages are the
// one-bit-per-stage restoring divider that forms the approach time.
// rst_n clears only the stage valid bits; data registers are not reset.
// Each stage loads when it is empty or the stage after it moves, so bubbles
// collapse and a stall on rsp holds every queued request in place.
module closest_approach_box_collision_top #(
    parameter int TIME_FRAC_BITS = cab_pkg::TIME_FRAC_BITS_DEF
) (
    input logic          clk,
    input logic          rst_n,
    cab_stream_if.sink   req,
    cab_stream_if.source rsp
);
    import cab_pkg::*;

    localparam int F = TIME_FRAC_BITS;
    localparam int DIV_STEPS = 17;
    localparam int RW = (F + 34 > 50) ? F + 34 : 50;
    localparam int EW = F + 34;
    localparam int HW = EW + 1;

    localparam int S_DIFF = 0;
    localparam int S_MUL = 1;
    localparam int S_SUM = 2;
    localparam int S_ABS = 3;
    localparam int S_NUM = 4;
    localparam int S_DIV = 5;
    localparam int S_SAT = S_DIV + DIV_STEPS;
    localparam int S_KMUL = S_SAT + 1;
    localparam int S_ERR = S_KMUL + 1;
    localparam int S_HIT = S_ERR + 1;
    localparam int NST = S_HIT + 1;

    typedef struct packed {
        logic signed [16:0]       dx;
        logic signed [16:0]       dy;
        logic signed [15:0]       vx;
        logic signed [15:0]       vy;
        logic        [12:0]       sum_w;
        logic        [12:0]       sum_h;
        logic signed [32:0]       pdx;
        logic signed [32:0]       pdy;
        logic signed [31:0]       pvx;
        logic signed [31:0]       pvy;
        logic signed [33:0]       dot;
        logic        [31:0]       den;
        logic                     neg;
        logic                     zero;
        logic        [32:0]       mag;
        logic        [RW-1:0]     rem;
        logic                     ovf;
        logic        [DIV_STEPS-1:0] q;
        logic signed [TIME_W-1:0] kq;
        logic signed [31:0]       px;
        logic signed [31:0]       py;
        logic signed [EW-1:0]     ex;
        logic signed [EW-1:0]     ey;
        logic                     hit;
        logic signed [TIME_W-1:0] k_out;
    } stage_t;

    stage_t             st_reg [NST];
    stage_t             st_next [NST];
    logic   [NST-1:0]   v_reg;
    logic   [NST:0]     en;

    logic [RW-1:0] dsh;
    logic [EW-1:0] aex;
    logic [EW-1:0] aey;

    // stall chain: a stage moves when empty or when its successor moves
    always_comb
    begin
        en[NST] = rsp.ready;
        for (int i = NST - 1; i >= 0; i--)
        begin
            en[i] = !v_reg[i] || en[i+1];
        end
    end

    assign req.ready = en[0];
    assign rsp.valid = v_reg[NST-1];
    assign rsp.data.hit = st_reg[NST-1].hit;
    assign rsp.data.approach_time = st_reg[NST-1].k_out;

    always_comb
    begin
        dsh = '0;
        aex = '0;
        aey = '0;

        st_next[0] = '0;
        for (int i = 1; i < NST; i++)
        begin
            st_next[i] = st_reg[i-1];
        end

        // centre offsets of the still box, summed sizes
        st_next[S_DIFF].dx = 17'(req.data.other_x) - 17'(req.data.self_x);
        st_next[S_DIFF].dy = 17'(req.data.other_y) - 17'(req.data.self_y);
        st_next[S_DIFF].vx = req.data.vel_x;
        st_next[S_DIFF].vy = req.data.vel_y;
        st_next[S_DIFF].sum_w = 13'(req.data.self_width) + 13'(req.data.other_width);
        st_next[S_DIFF].sum_h = 13'(req.data.self_height) + 13'(req.data.other_height);

        st_next[S_MUL].pdx = st_reg[S_MUL-1].dx * st_reg[S_MUL-1].vx;
        st_next[S_MUL].pdy = st_reg[S_MUL-1].dy * st_reg[S_MUL-1].vy;
        st_next[S_MUL].pvx = st_reg[S_MUL-1].vx * st_reg[S_MUL-1].vx;
        st_next[S_MUL].pvy = st_reg[S_MUL-1].vy * st_reg[S_MUL-1].vy;

        st_next[S_SUM].dot = 34'(st_reg[S_SUM-1].pdx) + 34'(st_reg[S_SUM-1].pdy);
        st_next[S_SUM].den = 32'($unsigned(st_reg[S_SUM-1].pvx))
                           + 32'($unsigned(st_reg[S_SUM-1].pvy));

        st_next[S_ABS].neg = st_reg[S_ABS-1].dot[33];
        st_next[S_ABS].zero = (st_reg[S_ABS-1].den == '0);
        st_next[S_ABS].mag = st_reg[S_ABS-1].dot[33] ? 33'(-st_reg[S_ABS-1].dot)
                                                     : 33'(st_reg[S_ABS-1].dot);

        // rounded numerator; quotient beyond 17 bits saturates anyway
        st_next[S_NUM].rem = (RW'(st_reg[S_NUM-1].mag) << F)
                           + RW'(st_reg[S_NUM-1].den >> 1);
        st_next[S_NUM].ovf = (st_next[S_NUM].rem >= (RW'(st_reg[S_NUM-1].den) << DIV_STEPS));
        st_next[S_NUM].q = '0;

        for (int j = 0; j < DIV_STEPS; j++)
        begin
            dsh = RW'(st_reg[S_DIV+j-1].den) << (DIV_STEPS - 1 - j);
            if (st_reg[S_DIV+j-1].rem >= dsh)
            begin
                st_next[S_DIV+j].rem = st_reg[S_DIV+j-1].rem - dsh;
                st_next[S_DIV+j].q[DIV_STEPS-1-j] = 1'b1;
            end
        end

        if (st_reg[S_SAT-1].zero)
        begin
            st_next[S_SAT].kq = '0;
        end
        else if (!st_reg[S_SAT-1].neg)
        begin
            if (st_reg[S_SAT-1].ovf || st_reg[S_SAT-1].q > 17'd32767)
                st_next[S_SAT].kq = K_MAX;
            else
                st_next[S_SAT].kq = TIME_W'(st_reg[S_SAT-1].q);
        end
        else
        begin
            if (st_reg[S_SAT-1].ovf || st_reg[S_SAT-1].q > 17'd32768)
                st_next[S_SAT].kq = K_MIN;
            else
                st_next[S_SAT].kq = TIME_W'(-st_reg[S_SAT-1].q);
        end

        st_next[S_KMUL].px = st_reg[S_KMUL-1].kq * st_reg[S_KMUL-1].vx;
        st_next[S_KMUL].py = st_reg[S_KMUL-1].kq * st_reg[S_KMUL-1].vy;

        // centre error at time k, scaled by 2^F
        st_next[S_ERR].ex = EW'(st_reg[S_ERR-1].px) - (EW'(st_reg[S_ERR-1].dx) <<< F);
        st_next[S_ERR].ey = EW'(st_reg[S_ERR-1].py) - (EW'(st_reg[S_ERR-1].dy) <<< F);

        aex = st_reg[S_HIT-1].ex[EW-1] ? EW'(-st_reg[S_HIT-1].ex) : EW'(st_reg[S_HIT-1].ex);
        aey = st_reg[S_HIT-1].ey[EW-1] ? EW'(-st_reg[S_HIT-1].ey) : EW'(st_reg[S_HIT-1].ey);
        st_next[S_HIT].hit = ({aex, 1'b0} < (HW'(st_reg[S_HIT-1].sum_w) << F))
                          && ({aey, 1'b0} < (HW'(st_reg[S_HIT-1].sum_h) << F));
        st_next[S_HIT].k_out = st_next[S_HIT].hit ? st_reg[S_HIT-1].kq : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            for (int i = 0; i < NST; i++)
            begin
                if (en[i])
                    v_reg[i] <= (i == 0) ? req.valid : v_reg[(i == 0) ? 0 : i - 1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < NST; i++)
        begin
            if (en[i])
                st_reg[i] <= st_next[i];
        end
    end

endmodule

>>> rtl/cab_checker.sv
// Port-level checks for the collision block, bound to the top level.
module cab_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        req_valid,
    input logic        req_ready,
    input logic        rsp_valid,
    input logic        rsp_ready,
    input logic        rsp_hit,
    input logic [15:0] rsp_time
);

    // a waiting response stays offered
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("response dropped while stalled");

    a_rsp_stable: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> $stable(rsp_hit) && $stable(rsp_time))
        else $error("stalled response changed");

    // a miss never reports an approach time
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_hit |-> rsp_time == 16'd0)
        else $error("miss with nonzero approach time");

    // with the output stage empty nothing can back up to the input
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !rsp_valid |-> req_ready)
        else $error("request blocked with empty output");

endmodule

bind closest_approach_box_collision_top cab_checker u_cab_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .rsp_hit   (rsp.data.hit),
    .rsp_time  (rsp.data.approach_time)
);
